[rtl/rle_pkg.sv]
// Shared types for the run-length byte decoder.
// Used by rle_core and rle_byte_decoder; no dependencies.
`timescale 1ns / 1ps

package rle_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 8;

  // decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RUN    = 3'b010,
    PH_LIT    = 3'b100
  } phase_e;

  // one decoded result
  typedef struct packed {
    logic             truncated;
    logic             block_done;
    logic [CntW-1:0]  repeat_count;
    logic [ByteW-1:0] out_byte;
  } res_t;

endpackage

[rtl/rle_core.sv]
// Phase tracking and result formation for the run-length decoder.
// Depends on rle_pkg.
`timescale 1ns / 1ps

module rle_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [rle_pkg::ByteW-1:0] byte_i,
  input  logic                     last_i,
  output logic                     res_valid_o,
  output rle_pkg::res_t            res_o
);

  rle_pkg::phase_e             phase_q, phase_d;
  logic [rle_pkg::CntW-1:0]    lit_left_q, lit_left_d;
  logic [rle_pkg::CntW-1:0]    run_len_q, run_len_d;
  logic                        more;

  assign more = lit_left_q > rle_pkg::CntW'(1);

  always_comb begin
    phase_d      = phase_q;
    lit_left_d   = lit_left_q;
    run_len_d    = run_len_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    unique case (phase_q)
      rle_pkg::PH_RUN: begin
        res_valid_o        = 1'b1;
        res_o.out_byte     = byte_i;
        res_o.repeat_count = run_len_q;
        res_o.block_done   = last_i;
        phase_d            = rle_pkg::PH_HEADER;
        run_len_d          = '0;
      end
      rle_pkg::PH_LIT: begin
        res_valid_o        = 1'b1;
        res_o.out_byte     = byte_i;
        res_o.repeat_count = rle_pkg::CntW'(1);
        res_o.block_done   = last_i;
        res_o.truncated    = last_i && more;
        if (more) begin
          lit_left_d = lit_left_q - rle_pkg::CntW'(1);
        end else begin
          lit_left_d = '0;
          phase_d    = rle_pkg::PH_HEADER;
        end
      end
      default: begin
        // header byte; invalid phase codes land here too
        if (byte_i[rle_pkg::ByteW-1]) begin
          // run of 257 - byte, 2 to 129
          run_len_d = rle_pkg::CntW'(9'd257 - {1'b0, byte_i});
          phase_d   = rle_pkg::PH_RUN;
        end else begin
          lit_left_d = byte_i + rle_pkg::CntW'(1);
          phase_d    = rle_pkg::PH_LIT;
        end
        // block ended on a header: status-only result
        res_valid_o      = last_i;
        res_o.block_done = 1'b1;
        res_o.truncated  = 1'b1;
      end
    endcase
    if (last_i) begin
      phase_d    = rle_pkg::PH_HEADER;
      lit_left_d = '0;
      run_len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rle_pkg::PH_HEADER;
      lit_left_q <= '0;
      run_len_q  <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      run_len_q  <= run_len_d;
    end
  end

endmodule

[rtl/rle_byte_decoder.sv]
// Top level of the run-length byte decoder: input handshake, decode core,
// output register with skid stage. Depends on rle_pkg and rle_core.
//
// Usage:
//   Slave stream carries one compressed byte per request (tdata) and marks the
//   last byte of a block with tlast. Master stream carries one result per
//   data byte: tdata holds the byte and its repeat count, tlast closes the
//   block and tuser flags a block that ended inside a run or literal group.
//   A repeat count of 0 marks a status-only result (block ended on a header).
//   Header bytes give no result unless they end a block.
//   Each result is registered before it shows on the master side.
//   Throughput: one byte per cycle, while the skid stage is empty.
//   Reset clears the phase to header, both counters and all valid flags.
//   When the receiver stalls, one further result is held in the skid stage;
//   the slave side drops tready only while that stage is full.
`timescale 1ns / 1ps

module rle_byte_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // block_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] repeat_count
  output logic        m_axis_tlast,   // block_done
  output logic        m_axis_tuser    // truncated
);

  logic          s_fire;
  logic          res_valid;
  rle_pkg::res_t res;
  rle_pkg::res_t out_q, skid_q;
  logic          out_valid_q, skid_valid_q;
  logic          out_free;

  assign s_axis_tready = !skid_valid_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  rle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s_fire),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= s_fire && res_valid;
    end else if (s_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.repeat_count, out_q.out_byte};
  assign m_axis_tlast  = out_q.block_done;
  assign m_axis_tuser  = out_q.truncated;

endmodule

[rtl/rle_checker.sv]
// Port-level checks for rle_byte_decoder, attached by bind.
// No package dependencies.
`timescale 1ns / 1ps

module rle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("master result changed while stalled");

  // truncation is only reported at a block end
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("truncated without block end");

  // status-only result carries a zero byte and is a truncated block end
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15:8] == 8'd0)
      |-> m_axis_tlast && m_axis_tuser && (m_axis_tdata[7:0] == 8'd0))
    else $error("malformed status result");

  // repeat count never exceeds the longest run
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:8] <= 8'd129)
    else $error("repeat count out of range");

endmodule

bind rle_byte_decoder rle_checker u_rle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

[verif/tb.sv]
// Self-checking bench for rle_byte_decoder: streams PackBits-style blocks in,
// predicts each decoded result and checks it field by field on the master side.
// Depends on rle_pkg and the rle_byte_decoder RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NumItems  = 1950;
  localparam int unsigned TailItems = 150;   // final stretch starts no new random gaps
  localparam int unsigned WdLimit   = 4000;
  localparam int unsigned DrainWait = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       hold;   // sender waits until every result is back
  } item_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0; // block_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] out_byte, [15:8] repeat_count
  logic        m_axis_tlast;         // block_done
  logic        m_axis_tuser;         // truncated

  item_t          byte_q[$];
  rle_pkg::res_t  pending_results[$];
  item_t          src_item;
  int             err_cnt = 0;

  // decoder state mirror
  rle_pkg::phase_e dec_phase = rle_pkg::PH_HEADER;
  logic [7:0]      lit_left  = '0;
  logic [7:0]      run_len   = '0;

  // idle control, per side
  logic [1:0]  src_mode = '0;
  logic [1:0]  snk_mode = '0;
  int unsigned src_span = 0;
  int unsigned snk_span = 0;
  int unsigned src_gap  = 0;
  int unsigned snk_gap  = 0;
  int unsigned wd_cnt   = 0;

  always #6 clk_i = ~clk_i;

  rle_byte_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Advance the decoder mirror by one byte; queue the result it yields, if any.
  function automatic void decode_byte(input logic [7:0] b, input logic eob);
    rle_pkg::res_t r;
    logic more;
    r = '0;
    case (dec_phase)
      rle_pkg::PH_RUN: begin
        r.out_byte     = b;
        r.repeat_count = run_len;
        r.block_done   = eob;
        pending_results.push_back(r);
        dec_phase = rle_pkg::PH_HEADER;
        run_len   = '0;
      end
      rle_pkg::PH_LIT: begin
        more           = lit_left > 8'd1;
        r.out_byte     = b;
        r.repeat_count = 8'd1;
        r.block_done   = eob;
        r.truncated    = eob && more;
        pending_results.push_back(r);
        if (more) begin
          lit_left = lit_left - 8'd1;
        end else begin
          lit_left  = '0;
          dec_phase = rle_pkg::PH_HEADER;
        end
      end
      default: begin
        if (b[7]) begin
          run_len   = 8'(9'd257 - {1'b0, b});
          dec_phase = rle_pkg::PH_RUN;
        end else begin
          lit_left  = b + 8'd1;
          dec_phase = rle_pkg::PH_LIT;
        end
        if (eob) begin
          r.block_done = 1'b1;
          r.truncated  = 1'b1;
          pending_results.push_back(r);
        end
      end
    endcase
    if (eob) begin
      dec_phase = rle_pkg::PH_HEADER;
      lit_left  = '0;
      run_len   = '0;
    end
  endfunction

  function automatic bit gap_roll(input logic [1:0] mode);
    case (mode)
      2'd1:    return $urandom_range(0, 7) == 0;
      2'd2:    return $urandom_range(0, 2) == 0;
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eob);
    item_t it;
    it.data = b;
    it.eob  = eob;
    it.hold = 1'b0;
    byte_q.push_back(it);
  endtask

  // One block: mostly well-formed runs and literal groups, some cut short,
  // some plain noise.
  task automatic add_block(input bit hold_first);
    item_t blk[$];
    item_t it;
    int    groups;
    int    cnt;
    int    cut;
    it = '0;
    if ($urandom_range(0, 11) == 0) begin
      cnt = $urandom_range(1, 6);
      for (int i = 0; i < cnt; i++) begin
        it.data = 8'($urandom_range(0, 255));
        it.eob  = $urandom_range(0, 3) == 0;
        blk.push_back(it);
      end
    end else begin
      groups = $urandom_range(1, 6);
      for (int g = 0; g < groups; g++) begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 9))
            0:       it.data = 8'h80;
            1:       it.data = 8'hFF;
            default: it.data = 8'($urandom_range(128, 255));
          endcase
          blk.push_back(it);
          it.data = 8'($urandom_range(0, 255));
          blk.push_back(it);
        end else begin
          case ($urandom_range(0, 11))
            0:       cnt = 128;
            1:       cnt = 1;
            2:       cnt = $urandom_range(1, 128);
            default: cnt = $urandom_range(1, 12);
          endcase
          it.data = 8'(cnt - 1);
          blk.push_back(it);
          for (int i = 0; i < cnt; i++) begin
            it.data = 8'($urandom_range(0, 255));
            blk.push_back(it);
          end
        end
      end
      if (blk.size() > 1 && $urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, blk.size() - 1);
        while (blk.size() > cut) void'(blk.pop_back());
      end
    end
    blk[blk.size()-1].eob = 1'b1;
    blk[0].hold = hold_first;
    foreach (blk[i]) byte_q.push_back(blk[i]);
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      src_gap       <= 0;
      src_span      <= 0;
      src_mode      <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (src_span == 0) begin
        src_mode <= 2'($urandom_range(0, 2));
        src_span <= $urandom_range(64, 256);
      end else begin
        src_span <= src_span - 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // request still pending, keep it on the bus
      end else if (src_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap       <= src_gap - 1;
      end else if (byte_q.size() == 0 ||
                   (byte_q[0].hold && pending_results.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() > TailItems && gap_roll(src_mode)) begin
        s_axis_tvalid <= 1'b0;
        src_gap       <= $urandom_range(0, 7);
      end else begin
        src_item       = byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= src_item.data;
        s_axis_tlast  <= src_item.eob;
      end
    end
  end

  // sink side: check results, throttle tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap       <= 0;
      snk_span      <= 0;
      snk_mode      <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: out_byte %0d repeat_count %0d",
                 m_axis_tdata[7:0], m_axis_tdata[15:8]);
          err_cnt++;
        end else begin
          rle_pkg::res_t want;
          want = pending_results.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte) begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, m_axis_tdata[7:0]);
            err_cnt++;
          end
          if (m_axis_tdata[15:8] !== want.repeat_count) begin
            $error("repeat_count: expected %0d, got %0d",
                   want.repeat_count, m_axis_tdata[15:8]);
            err_cnt++;
          end
          if (m_axis_tlast !== want.block_done) begin
            $error("block_done: expected %0b, got %0b", want.block_done, m_axis_tlast);
            err_cnt++;
          end
          if (m_axis_tuser !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, m_axis_tuser);
            err_cnt++;
          end
        end
      end
      if (snk_span == 0) begin
        snk_mode <= 2'($urandom_range(0, 2));
        snk_span <= $urandom_range(64, 256);
      end else begin
        snk_span <= snk_span - 1;
      end
      if (byte_q.size() <= TailItems) begin
        m_axis_tready <= 1'b1;
      end else if (snk_gap != 0) begin
        m_axis_tready <= 1'b0;
        snk_gap       <= snk_gap - 1;
      end else if (gap_roll(snk_mode)) begin
        m_axis_tready <= 1'b0;
        snk_gap       <= $urandom_range(0, 7);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no request accepted on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        wd_cnt <= 0;
      end else if (wd_cnt >= WdLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        wd_cnt <= wd_cnt + 1;
      end
    end
  end

  initial begin
    int blk_cnt;
    blk_cnt = 0;
    // directed: extremes and each block-end case
    add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);                         // single literal
    add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);                         // shortest run
    add_byte(8'h80, 1'b0); add_byte(8'hA5, 1'b0);                         // longest run
    add_byte(8'h7F, 1'b0); add_byte(8'h01, 1'b0); add_byte(8'hFE, 1'b1);  // literals cut short
    add_byte(8'h02, 1'b0); add_byte(8'h11, 1'b0); add_byte(8'h22, 1'b0);
    add_byte(8'h33, 1'b1);                                                // group ends with block
    add_byte(8'h05, 1'b1);                                                // ends on literal header
    add_byte(8'h80, 1'b1);                                                // ends on run header
    add_byte(8'h81, 1'b0); add_byte(8'h3C, 1'b1);                         // ends on run value
    add_byte(8'h03, 1'b0); add_byte(8'h55, 1'b0); add_byte(8'hAA, 1'b1);
    add_byte(8'h00, 1'b0); add_byte(8'h7F, 1'b1);
    while (byte_q.size() < NumItems) begin
      add_block(blk_cnt % 40 == 0);
      blk_cnt++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[rle_byte_decoder.f]
rtl/rle_pkg.sv
rtl/rle_core.sv
rtl/rle_byte_decoder.sv
rtl/rle_checker.sv
verif/tb.sv
